// ===== hw/rtl/slr_pkg.sv =====
package slr_pkg;

	localparam int unsigned CodeW  = 16;
	localparam int unsigned FlagW  = 16;
	localparam int unsigned RuleAw = 10;
	localparam int unsigned RuleDepth = 1 << RuleAw;

	// scan codes of the tracked modifiers
	localparam logic [7:0] MC_LSHIFT = 8'h2A;
	localparam logic [7:0] MC_RSHIFT = 8'h36;
	localparam logic [7:0] MC_CTRL   = 8'h1D;
	localparam logic [7:0] MC_ALT    = 8'h38;
	localparam logic [7:0] MC_LWIN   = 8'h5B;
	localparam logic [7:0] MC_RWIN   = 8'h5C;
	localparam logic [CodeW-1:0] MC_MAX8 = 16'h00FF;

	localparam logic [FlagW-1:0] FL_BREAK = 16'h0001;
	localparam logic [FlagW-1:0] FL_E0    = 16'h0002;
	localparam logic [FlagW-1:0] FL_E1    = 16'h0004;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_RULE  = 1'b1;

	localparam logic [1:0] MODE_HARD_BYPASS = 2'd0;
	localparam logic [1:0] MODE_SOFT_BYPASS = 2'd1;
	localparam logic [1:0] MODE_ACTIVE      = 2'd2;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_WRAP = 1'b1;

	localparam logic [1:0] OUTC_BYPASS   = 2'd0;
	localparam logic [1:0] OUTC_UNMAPPED = 2'd1;
	localparam logic [1:0] OUTC_REMAP    = 2'd2;
	localparam logic [1:0] OUTC_WRAP     = 2'd3;

	typedef struct packed {
		logic       valid;
		logic       out_shift;
		logic       out_e0;
		logic [7:0] out_code;
	} slr_entry_t;

	typedef struct packed {
		logic              we;
		logic [RuleAw-1:0] waddr;
		slr_entry_t        wdata;
		logic              re;
		logic [RuleAw-1:0] raddr;
	} slr_ram_req_t;

	// next held-modifier set after one event
	function automatic logic [7:0] mod_update(logic [7:0] held, logic [CodeW-1:0] mc,
			logic [FlagW-1:0] flags);
		logic [7:0] nxt;
		logic       brk;
		logic       e0;
		logic [2:0] bitn;
		logic       hit;
		nxt  = held;
		brk  = flags[0];
		e0   = flags[1];
		bitn = 3'd0;
		hit  = 1'b0;
		if (mc[CodeW-1:8] == '0) begin
			if (!e0 && mc[7:0] == MC_LSHIFT) begin
				bitn = 3'd0; hit = 1'b1;
			end else if (!e0 && mc[7:0] == MC_RSHIFT) begin
				bitn = 3'd1; hit = 1'b1;
			end else if (mc[7:0] == MC_CTRL) begin
				bitn = e0 ? 3'd3 : 3'd2; hit = 1'b1;
			end else if (mc[7:0] == MC_ALT) begin
				bitn = e0 ? 3'd5 : 3'd4; hit = 1'b1;
			end else if (mc[7:0] == MC_LWIN) begin
				bitn = 3'd6; hit = 1'b1;
			end else if (mc[7:0] == MC_RWIN) begin
				bitn = 3'd7; hit = 1'b1;
			end
		end
		if (hit) begin
			nxt[bitn] = ~brk;
		end
		return nxt;
	endfunction

endpackage

// ===== hw/rtl/scancode_layout_remapper_top.sv =====
// An accepted event and its rule read are registered in the lookup stage;
// each result word is then registered at the output. Throughput: one event
// per cycle while out_stall is low and each gives one word; a shift-wrapped
// event gives three words, holding the lookup stage until the last. Reset:
// rule memory swept invalid, in_stall high; config writes taken at once.
module scancode_layout_remapper_top
	import slr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [1:0]       cfg_data,

	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	input  logic [CodeW-1:0] make_code,
	input  logic [FlagW-1:0] key_flags,
	input  logic [7:0]       rule_in_code,
	input  logic             rule_in_e0,
	input  logic             rule_in_shift,
	input  logic [7:0]       rule_out_code,
	input  logic             rule_out_e0,
	input  logic             rule_out_shift,
	input  logic             rule_valid,

	output logic             out_valid,
	input  logic             out_stall,
	output logic [CodeW-1:0] out_make_code,
	output logic [FlagW-1:0] out_flags,
	output logic             remapped,
	output logic [1:0]       outcome,
	output logic             last
);

	typedef enum logic [1:0] {
		CLS_BYPASS,
		CLS_WIDE,
		CLS_LOOKUP
	} cls_t;

	logic [1:0]        mode_q;
	logic              wrap_en_q;
	logic [7:0]        mod_q;
	logic              clr_busy_q;
	logic [RuleAw-1:0] clr_idx_q;

	logic              s1_v_q;
	cls_t              cls_s1;
	logic [CodeW-1:0]  mc_s1;
	logic [FlagW-1:0]  flags_s1;
	logic              phys_s1;
	logic [1:0]        cnt_s1;

	logic              out_v_q;
	logic [CodeW-1:0]  out_mc_q;
	logic [FlagW-1:0]  out_flags_q;
	logic              out_rem_q;
	logic [1:0]        out_outc_q;
	logic              out_last_q;

	logic              acc;
	logic              acc_ev;
	logic              acc_rule;
	logic [7:0]        mod_nxt;
	logic              phys_nxt;
	slr_ram_req_t      ram_req;
	slr_entry_t        ent;
	logic              load;
	logic              pop;

	logic [CodeW-1:0]  w_mc;
	logic [FlagW-1:0]  w_flags;
	logic              w_rem;
	logic [1:0]        w_outc;
	logic              w_last;

	assign cfg_ready = 1'b1;
	assign acc       = in_valid && !in_stall;
	assign acc_ev    = acc && kind == KIND_EVENT;
	assign acc_rule  = acc && kind == KIND_RULE;
	assign load      = s1_v_q && (!out_v_q || !out_stall);
	assign pop       = load && w_last;
	assign in_stall  = clr_busy_q || (s1_v_q && !pop);

	assign mod_nxt  = (mode_q == MODE_HARD_BYPASS) ? mod_q
		: mod_update(mod_q, make_code, key_flags);
	assign phys_nxt = |mod_nxt[1:0];

	always_comb begin
		ram_req = '0;
		if (clr_busy_q) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = clr_idx_q;
		end else if (acc_rule) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = {rule_in_e0, rule_in_shift, rule_in_code};
			if (rule_valid) begin
				ram_req.wdata = '{valid: 1'b1, out_shift: rule_out_shift,
					out_e0: rule_out_e0, out_code: rule_out_code};
			end
		end
		ram_req.re    = acc_ev;
		ram_req.raddr = {key_flags[1], phys_nxt, make_code[7:0]};
	end

	slr_rule_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ent)
	);

	// build the word at position cnt_s1 of the current event
	always_comb begin
		logic             want;
		logic             no_wrap;
		logic [FlagW-1:0] mflags;
		logic [FlagW-1:0] down;
		logic [FlagW-1:0] up;
		want    = ent.out_shift;
		mflags  = ent.out_e0 ? (flags_s1 | FL_E0) : (flags_s1 & ~FL_E0);
		down    = flags_s1 & ~(FL_E0 | FL_E1 | FL_BREAK);
		up      = down | FL_BREAK;
		no_wrap = mc_s1[7:0] == MC_LSHIFT || mc_s1[7:0] == MC_RSHIFT
			|| (flags_s1 & FL_E1) != '0 || phys_s1 == want || !wrap_en_q;
		w_mc    = mc_s1;
		w_flags = flags_s1;
		w_rem   = 1'b0;
		w_outc  = OUTC_UNMAPPED;
		w_last  = 1'b1;
		case (cls_s1)
			CLS_BYPASS: begin
				w_outc = OUTC_BYPASS;
			end
			CLS_LOOKUP: begin
				if (ent.valid && ent.out_code != 8'd0) begin
					w_rem = 1'b1;
					if (no_wrap) begin
						w_mc    = {8'd0, ent.out_code};
						w_flags = mflags;
						w_outc  = OUTC_REMAP;
					end else begin
						w_outc = OUTC_WRAP;
						case (cnt_s1)
							2'd0: begin
								w_mc    = {8'd0, MC_LSHIFT};
								w_flags = want ? down : up;
								w_last  = 1'b0;
							end
							2'd1: begin
								w_mc    = {8'd0, ent.out_code};
								w_flags = mflags;
								w_last  = 1'b0;
							end
							default: begin
								w_mc    = {8'd0, MC_LSHIFT};
								w_flags = want ? up : down;
							end
						endcase
					end
				end
			end
			default: begin
				w_outc = OUTC_UNMAPPED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_HARD_BYPASS;
			wrap_en_q  <= 1'b1;
			mod_q      <= '0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			s1_v_q     <= 1'b0;
			cnt_s1     <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE: mode_q    <= cfg_data;
					CFG_WRAP: wrap_en_q <= cfg_data[0];
					default:  mode_q    <= mode_q;
				endcase
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == RuleAw'(RuleDepth - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (acc_ev) begin
				mod_q  <= mod_nxt;
				s1_v_q <= 1'b1;
			end else if (pop) begin
				s1_v_q <= 1'b0;
			end
			// advance the word counter, restart on the final word
			if (pop) begin
				cnt_s1 <= '0;
			end else if (load) begin
				cnt_s1 <= cnt_s1 + 1'b1;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_ev) begin
			mc_s1    <= make_code;
			flags_s1 <= key_flags;
			phys_s1  <= phys_nxt;
			if (mode_q == MODE_HARD_BYPASS || mode_q == MODE_SOFT_BYPASS) begin
				cls_s1 <= CLS_BYPASS;
			end else if (make_code > MC_MAX8) begin
				cls_s1 <= CLS_WIDE;
			end else begin
				cls_s1 <= CLS_LOOKUP;
			end
		end
		if (load) begin
			out_mc_q    <= w_mc;
			out_flags_q <= w_flags;
			out_rem_q   <= w_rem;
			out_outc_q  <= w_outc;
			out_last_q  <= w_last;
		end
	end

	assign out_valid     = out_v_q;
	assign out_make_code = out_mc_q;
	assign out_flags     = out_flags_q;
	assign remapped      = out_rem_q;
	assign outcome       = out_outc_q;
	assign last          = out_last_q;

endmodule

// ===== hw/rtl/slr_rule_ram.sv =====
module slr_rule_ram
	import slr_pkg::*;
(
	input  logic         clk,
	input  slr_ram_req_t req,
	output slr_entry_t   rdata
);

	slr_entry_t mem [RuleDepth];
	slr_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
